// ===== rtl/core/fscc_pkg.sv =====
// Shared types, constants and field widths of the fan speed command controller.
`default_nettype none
package fscc_pkg;

  localparam int SAMPLE_WIDTH = 12;
  localparam int THR_W        = 12;
  localparam int DUTY_W       = 4;
  localparam int CFG_W        = 12;
  localparam int CFG_IDX_W    = 3;
  localparam int CMP_W        = (SAMPLE_WIDTH > THR_W) ? SAMPLE_WIDTH : THR_W;

  // transaction queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  // result counter inside one reply (up to nine bytes)
  localparam int RES_IDX_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_ZERO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_ONE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_TWO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_DUTY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_MAN  = 3'd6;

  localparam logic [THR_W-1:0]  LOW_THR_RST   = 12'd1000;
  localparam logic [THR_W-1:0]  HIGH_THR_RST  = 12'd3000;
  localparam logic [DUTY_W-1:0] DUTY_ZERO_RST = 4'd0;
  localparam logic [DUTY_W-1:0] DUTY_ONE_RST  = 4'd4;
  localparam logic [DUTY_W-1:0] DUTY_TWO_RST  = 4'd9;

  // frame bytes and commands
  localparam logic [7:0] STX          = 8'h02;
  localparam logic [7:0] ETX          = 8'h03;
  localparam logic [7:0] CMD_POWER    = 8'h01;
  localparam logic [7:0] CMD_MODE     = 8'h02;
  localparam logic [7:0] CMD_LEVEL    = 8'h03;
  localparam logic [7:0] CMD_STATUS   = 8'h04;
  localparam logic [7:0] REPLY_FLAG   = 8'h80;
  localparam logic [7:0] REPLY_STATUS = 8'h84;
  localparam logic [7:0] LEN_SHORT    = 8'h01;
  localparam logic [7:0] LEN_STATUS   = 8'h05;
  localparam logic [7:0] CODE_OK      = 8'h00;
  localparam logic [7:0] CODE_BADDATA = 8'h01;
  localparam logic [7:0] CODE_POWEROFF = 8'h02;
  localparam logic [7:0] CODE_BADLEN  = 8'hff;
  localparam logic [7:0] CLS_LOW      = 8'h00;
  localparam logic [7:0] CLS_MID      = 8'h01;
  localparam logic [7:0] CLS_HIGH     = 8'hff;

  localparam logic [2:0] FRAME_LAST_POS = 3'd4;

  typedef enum logic [1:0] {
    RPL_NONE,
    RPL_SHORT,
    RPL_STATUS
  } reply_kind_t;

  typedef struct packed {
    logic                    kind;
    logic [7:0]              rx_byte;
    logic [SAMPLE_WIDTH-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        tx_byte;
    logic              tx_valid;
    logic              last;
    logic [DUTY_W-1:0] fan_duty;
    logic              store_request;
    logic [DUTY_W-1:0] store_duty;
    logic              store_manual;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    reply_kind_t       rtype;
    logic [7:0]        cmd_byte;
    logic [7:0]        code;
    logic              st_power;
    logic              st_manual;
    logic [DUTY_W-1:0] st_lvl;
    logic [7:0]        st_cls;
    logic [DUTY_W-1:0] fan_duty;
    logic              store_request;
    logic [DUTY_W-1:0] store_duty;
    logic              store_manual;
  } desc_t;

endpackage
`default_nettype wire

// ===== rtl/core/fan_speed_command_controller_unit.sv =====
// Top level of the fan speed command controller.
// Each input transaction (a serial byte or a sensor sample) is taken by the
// front end while the queue has room; the front end updates all controller
// state and classifies the reply; a two-entry queue holds classified
// transactions for the back end, which sends one result transaction per cycle
// while out_ready allows it, through a registered output: one result for an
// item without reply, five for a command reply and nine for a status reply.
// The output port therefore sets the sustained rate, with up to two items absorbed while replies drain.
// Configuration writes take effect at the clock edge; no reset clearing pass.
`default_nettype none
module fan_speed_command_controller_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [fscc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fscc_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire fscc_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output fscc_pkg::out_item_t                 out_data
);

  fscc_pkg::desc_t front_desc;
  fscc_pkg::desc_t head;
  logic            accept;
  logic            full;
  logic            empty;
  logic            pop;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  fscc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (in_data),
    .desc      (front_desc)
  );

  fscc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_desc),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  fscc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/core/fscc_front.sv =====
// Front end: frame assembly, command decode, automatic duty and persist tracking.
`default_nettype none
module fscc_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [fscc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fscc_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                             accept,
  input  wire fscc_pkg::in_item_t               item,
  output fscc_pkg::desc_t                       desc
);

  logic [fscc_pkg::THR_W-1:0]        low_thr;
  logic [fscc_pkg::THR_W-1:0]        high_thr;
  logic [fscc_pkg::DUTY_W-1:0]       duty_zero;
  logic [fscc_pkg::DUTY_W-1:0]       duty_one;
  logic [fscc_pkg::DUTY_W-1:0]       duty_two;

  logic [2:0]                        frame_pos, frame_pos_next;
  logic [7:0]                        cmd_byte, cmd_byte_next;
  logic [7:0]                        len_byte, len_byte_next;
  logic [7:0]                        data_byte, data_byte_next;
  logic                              power_on, power_on_next;
  logic                              manual, manual_next;
  logic [fscc_pkg::DUTY_W-1:0]       remembered, remembered_next;
  logic [fscc_pkg::DUTY_W-1:0]       driven, driven_next;
  logic [fscc_pkg::DUTY_W-1:0]       saved_duty;
  logic                              saved_manual;
  logic [fscc_pkg::SAMPLE_WIDTH-1:0] sample, sample_next;

  logic [fscc_pkg::CMP_W-1:0] cmp_sample, cmp_low, cmp_high;
  logic [fscc_pkg::CMP_W-1:0] cmp_sample_next;
  logic [7:0] b;

  assign cmp_sample      = fscc_pkg::CMP_W'(sample);
  // newest sample, taken straight from the item to keep the decode loop-free
  assign cmp_sample_next = item.kind ? fscc_pkg::CMP_W'(item.adc_sample) : cmp_sample;
  assign cmp_low         = fscc_pkg::CMP_W'(low_thr);
  assign cmp_high        = fscc_pkg::CMP_W'(high_thr);
  assign b               = item.rx_byte;

  always_comb begin
    frame_pos_next  = frame_pos;
    cmd_byte_next   = cmd_byte;
    len_byte_next   = len_byte;
    data_byte_next  = data_byte;
    power_on_next   = power_on;
    manual_next     = manual;
    remembered_next = remembered;
    driven_next     = driven;
    sample_next     = sample;

    desc            = '0;
    desc.rtype      = fscc_pkg::RPL_NONE;
    desc.cmd_byte   = fscc_pkg::REPLY_FLAG | cmd_byte;
    desc.code       = fscc_pkg::CODE_OK;

    if (item.kind) begin
      sample_next = item.adc_sample;
    end else if (frame_pos >= fscc_pkg::FRAME_LAST_POS) begin
      frame_pos_next = '0;
      if (b == fscc_pkg::ETX &&
          (cmd_byte == fscc_pkg::CMD_POWER || cmd_byte == fscc_pkg::CMD_MODE ||
           cmd_byte == fscc_pkg::CMD_LEVEL)) begin
        desc.rtype = fscc_pkg::RPL_SHORT;
        if (len_byte != fscc_pkg::LEN_SHORT) begin
          desc.code = fscc_pkg::CODE_BADLEN;
        end else begin
          case (cmd_byte)
            fscc_pkg::CMD_POWER: begin
              if (data_byte == 8'd1) begin
                power_on_next = 1'b1;
                driven_next   = remembered;
              end else if (data_byte == 8'd0) begin
                power_on_next   = 1'b0;
                remembered_next = driven;
                driven_next     = duty_zero;
                manual_next     = 1'b1;
              end else begin
                desc.code = fscc_pkg::CODE_BADDATA;
              end
            end
            fscc_pkg::CMD_MODE: begin
              if (data_byte > 8'd1) begin
                desc.code = fscc_pkg::CODE_BADDATA;
              end else if (!power_on) begin
                desc.code = fscc_pkg::CODE_POWEROFF;
              end else begin
                manual_next = data_byte[0];
              end
            end
            default: begin
              if (data_byte > 8'd2) begin
                desc.code = fscc_pkg::CODE_BADDATA;
              end else if (!power_on) begin
                desc.code = fscc_pkg::CODE_POWEROFF;
              end else begin
                case (data_byte[1:0])
                  2'd0:    driven_next = duty_zero;
                  2'd1:    driven_next = duty_one;
                  default: driven_next = duty_two;
                endcase
                remembered_next = driven_next;
                manual_next     = 1'b1;
              end
            end
          endcase
        end
      end
    end else begin
      case (frame_pos)
        3'd1:    cmd_byte_next  = b;
        3'd2:    len_byte_next  = b;
        3'd3:    data_byte_next = b;
        default: ;
      endcase
      if (frame_pos == 3'd3 && cmd_byte == fscc_pkg::CMD_STATUS && b == fscc_pkg::ETX) begin
        frame_pos_next = '0;
        if (len_byte != 8'd0) begin
          desc.rtype    = fscc_pkg::RPL_SHORT;
          desc.cmd_byte = fscc_pkg::REPLY_STATUS;
          desc.code     = fscc_pkg::CODE_BADLEN;
        end else begin
          desc.rtype     = fscc_pkg::RPL_STATUS;
          desc.st_power  = power_on;
          desc.st_manual = manual;
          if (driven == duty_zero)     desc.st_lvl = fscc_pkg::DUTY_W'(0);
          else if (driven == duty_one) desc.st_lvl = fscc_pkg::DUTY_W'(1);
          else if (driven == duty_two) desc.st_lvl = fscc_pkg::DUTY_W'(2);
          else                         desc.st_lvl = driven;
          if (cmp_sample >= cmp_high)    desc.st_cls = fscc_pkg::CLS_HIGH;
          else if (cmp_sample < cmp_low) desc.st_cls = fscc_pkg::CLS_LOW;
          else                           desc.st_cls = fscc_pkg::CLS_MID;
        end
      end else begin
        frame_pos_next = frame_pos + 3'd1;
      end
    end

    // automatic mode follows the newest sample
    if (power_on_next && !manual_next) begin
      if (cmp_sample_next < cmp_low)        driven_next = duty_zero;
      else if (cmp_sample_next >= cmp_high) driven_next = duty_two;
      else                                  driven_next = duty_one;
      remembered_next = driven_next;
    end

    desc.fan_duty = driven_next;
    if (remembered_next != saved_duty || manual_next != saved_manual) begin
      desc.store_request = 1'b1;
      desc.store_duty    = remembered_next;
      desc.store_manual  = manual_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr      <= fscc_pkg::LOW_THR_RST;
      high_thr     <= fscc_pkg::HIGH_THR_RST;
      duty_zero    <= fscc_pkg::DUTY_ZERO_RST;
      duty_one     <= fscc_pkg::DUTY_ONE_RST;
      duty_two     <= fscc_pkg::DUTY_TWO_RST;
      frame_pos    <= '0;
      power_on     <= 1'b0;
      manual       <= 1'b0;
      remembered   <= '0;
      driven       <= '0;
      saved_duty   <= '0;
      saved_manual <= 1'b0;
      sample       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fscc_pkg::REG_LOW_THR:   low_thr   <= cfg_data[fscc_pkg::THR_W-1:0];
        fscc_pkg::REG_HIGH_THR:  high_thr  <= cfg_data[fscc_pkg::THR_W-1:0];
        fscc_pkg::REG_DUTY_ZERO: duty_zero <= cfg_data[fscc_pkg::DUTY_W-1:0];
        fscc_pkg::REG_DUTY_ONE:  duty_one  <= cfg_data[fscc_pkg::DUTY_W-1:0];
        fscc_pkg::REG_DUTY_TWO:  duty_two  <= cfg_data[fscc_pkg::DUTY_W-1:0];
        fscc_pkg::REG_BOOT_DUTY: begin
          remembered <= cfg_data[fscc_pkg::DUTY_W-1:0];
          saved_duty <= cfg_data[fscc_pkg::DUTY_W-1:0];
        end
        fscc_pkg::REG_BOOT_MAN: begin
          manual       <= cfg_data[0];
          saved_manual <= cfg_data[0];
        end
        default: ;
      endcase
    end else if (accept) begin
      frame_pos  <= frame_pos_next;
      power_on   <= power_on_next;
      manual     <= manual_next;
      remembered <= remembered_next;
      driven     <= driven_next;
      sample     <= sample_next;
      if (desc.store_request) begin
        saved_duty   <= remembered_next;
        saved_manual <= manual_next;
      end
    end
  end

  // frame bytes carry no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_byte  <= cmd_byte_next;
      len_byte  <= len_byte_next;
      data_byte <= data_byte_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    frame_pos <= fscc_pkg::FRAME_LAST_POS)
    else $error("frame position out of range");

  a_saved_tracks: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_we |=> (saved_duty == remembered && saved_manual == manual))
    else $error("saved pair does not follow remembered pair");

endmodule
`default_nettype wire

// ===== rtl/core/fscc_queue.sv =====
// Short queue of classified transactions between front and back.
`default_nettype none
module fscc_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire fscc_pkg::desc_t  push_data,
  output logic                  full,
  output logic                  empty,
  input  wire logic             pop,
  output fscc_pkg::desc_t       head
);

  fscc_pkg::desc_t                 mem [fscc_pkg::QDEPTH];
  logic [fscc_pkg::QPTR_W-1:0]     wr_ptr;
  logic [fscc_pkg::QPTR_W-1:0]     rd_ptr;
  logic [fscc_pkg::QCNT_W-1:0]     count;

  assign full  = (count == fscc_pkg::QCNT_W'(fscc_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + fscc_pkg::QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + fscc_pkg::QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + fscc_pkg::QCNT_W'(1);
        2'b01:   count <= count - fscc_pkg::QCNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== rtl/core/fscc_back.sv =====
// Back end: expands each classified item into its result items.
`default_nettype none
module fscc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             empty,
  input  wire fscc_pkg::desc_t  head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output fscc_pkg::out_item_t   out_data
);

  logic [fscc_pkg::RES_IDX_W-1:0] idx;
  logic [fscc_pkg::RES_IDX_W-1:0] last_idx;
  logic                           load;
  logic                           is_last;
  logic [7:0]                     byte_sel;
  fscc_pkg::out_item_t            res;

  always_comb begin
    case (head.rtype)
      fscc_pkg::RPL_SHORT:  last_idx = fscc_pkg::RES_IDX_W'(4);
      fscc_pkg::RPL_STATUS: last_idx = fscc_pkg::RES_IDX_W'(8);
      default:              last_idx = '0;
    endcase
  end

  always_comb begin
    byte_sel = 8'h00;
    if (head.rtype == fscc_pkg::RPL_SHORT) begin
      case (idx)
        4'd0:    byte_sel = fscc_pkg::STX;
        4'd1:    byte_sel = head.cmd_byte;
        4'd2:    byte_sel = fscc_pkg::LEN_SHORT;
        4'd3:    byte_sel = head.code;
        default: byte_sel = fscc_pkg::ETX;
      endcase
    end else if (head.rtype == fscc_pkg::RPL_STATUS) begin
      case (idx)
        4'd0:    byte_sel = fscc_pkg::STX;
        4'd1:    byte_sel = fscc_pkg::REPLY_STATUS;
        4'd2:    byte_sel = fscc_pkg::LEN_STATUS;
        4'd3:    byte_sel = fscc_pkg::CODE_OK;
        4'd4:    byte_sel = {7'd0, head.st_power};
        4'd5:    byte_sel = {7'd0, head.st_manual};
        4'd6:    byte_sel = {{(8 - fscc_pkg::DUTY_W){1'b0}}, head.st_lvl};
        4'd7:    byte_sel = head.st_cls;
        default: byte_sel = fscc_pkg::ETX;
      endcase
    end
  end

  assign is_last = (idx == last_idx);
  assign load    = !empty && (!out_valid || out_ready);
  assign pop     = load && is_last;

  always_comb begin
    res               = '0;
    res.tx_byte       = byte_sel;
    res.tx_valid      = (head.rtype != fscc_pkg::RPL_NONE);
    res.last          = is_last;
    res.fan_duty      = head.fan_duty;
    if (is_last) begin
      res.store_request = head.store_request;
      res.store_duty    = head.store_duty;
      res.store_manual  = head.store_manual;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? '0 : idx + fscc_pkg::RES_IDX_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= res;
  end

  a_idx_in_reply: assert property (@(posedge clk) disable iff (rst)
    !empty |-> idx <= last_idx)
    else $error("reply index past end of reply");

  a_store_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.store_request |-> out_data.last)
    else $error("persist request on a non-final transaction");

endmodule
`default_nettype wire
